@@ src/quaternion_to_euler_zyx_unit_assert.svh @@
// Assertion macros for the quaternion to Euler angle unit.
// Relies on clk_i and rst_ni being in scope where the macros are used.
`ifndef QUATERNION_TO_EULER_ZYX_UNIT_ASSERT_SVH
`define QUATERNION_TO_EULER_ZYX_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define Q2E_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication after a fixed number of cycles.
`define Q2E_ASSERT_DELAY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##dly (cons)) \
    else $error("latency check failed");

`endif

@@ src/q2e_pkg.sv @@
// Shared types, widths and the CORDIC arctangent table for the
// quaternion to ZYX Euler unit. No dependencies.
package q2e_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN          = 24;
  localparam int CORD_W            = 36;   // CORDIC datapath width
  localparam int SUM_W             = 33;   // sum of two Q.28 products
  localparam int P_W               = 34;   // 2(xz - wy)
  localparam int NP_W              = 30;   // -p in the non-lock range
  localparam int SQ_RAD_W          = 58;   // radicand 2^56 - p^2, padded
  localparam int SQ_ROOT_W         = 29;
  localparam int SQ_REM_W          = 32;

  localparam logic signed [15:0] PITCH_MAX = 16'sd16384;
  localparam logic signed [15:0] PITCH_MIN = -16'sd16384;

  // atan(2^-i), 2^32 = 2*pi
  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               gimbal_lock;
  } euler_t;

  // Operands that travel alongside the square root
  typedef struct packed {
    logic                    lock;
    logic                    p_pos;
    logic signed [NP_W-1:0]  neg_p;
    logic signed [SUM_W-1:0] roll_y;
    logic signed [SUM_W-1:0] roll_x;
    logic signed [SUM_W-1:0] yaw_y;
    logic signed [SUM_W-1:0] yaw_x;
  } side_t;

endpackage

@@ src/quaternion_to_euler_zyx_unit.sv @@
// Quaternion (Q1.14) to ZYX Euler angles (binary angles, 32768 = pi). One
// request is taken every clock cycle; busy never rises. Each result appears
// on result_o with done_o high for one cycle, after passing 4 product/radicand
// stages, 29 square-root stages, min(CORDIC_STAGES, 24) + 2 CORDIC stages and
// 1 output stage; results leave in request order and must be captured in that
// cycle since the receiver cannot stall.
// Depends on q2e_pkg, q2e_front, q2e_sqrt, q2e_cordic and the assert header.
`include "quaternion_to_euler_zyx_unit_assert.svh"

module quaternion_to_euler_zyx_unit #(
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  q2e_pkg::quat_t  quat_i,
  output logic            done_o,
  output q2e_pkg::euler_t result_o
);
  import q2e_pkg::*;

  localparam int NS  = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
  localparam int LAT = 4 + SQ_ROOT_W + NS + 2 + 1;

  logic                 f_valid, s_valid;
  side_t                f_side, s_side;
  logic [SQ_RAD_W-1:0]  f_rad;
  logic [SQ_ROOT_W-1:0] s_root;

  logic               r_valid, p_valid, y_valid;
  logic signed [15:0] r_ang, p_ang, y_ang;
  logic               r_lock;
  logic [1:0]         p_sd, y_sd;

  logic   done_q;
  euler_t res_q;
  logic signed [15:0] y_mag, p_clamp;

  assign busy = 1'b0;

  q2e_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .quat_i  (quat_i),
    .valid_o (f_valid),
    .side_o  (f_side),
    .rad_o   (f_rad)
  );

  q2e_sqrt #(.SIDE_W($bits(side_t))) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .rad_i   (f_rad),
    .side_i  (f_side),
    .valid_o (s_valid),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  // roll
  q2e_cordic #(.STAGES(CORDIC_STAGES), .W(CORD_W), .SIDE_W(1)) u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_valid),
    .y_i     (CORD_W'(s_side.roll_y)),
    .x_i     (CORD_W'(s_side.roll_x)),
    .side_i  (s_side.lock),
    .valid_o (r_valid),
    .angle_o (r_ang),
    .side_o  (r_lock)
  );

  // pitch as atan2(-p, sqrt(1 - p^2))
  q2e_cordic #(.STAGES(CORDIC_STAGES), .W(CORD_W), .SIDE_W(2)) u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_valid),
    .y_i     (CORD_W'(s_side.neg_p)),
    .x_i     ({{(CORD_W-SQ_ROOT_W){1'b0}}, s_root}),
    .side_i  ({s_side.lock, s_side.p_pos}),
    .valid_o (p_valid),
    .angle_o (p_ang),
    .side_o  (p_sd)
  );

  // yaw, operands already picked per branch
  q2e_cordic #(.STAGES(CORDIC_STAGES), .W(CORD_W), .SIDE_W(2)) u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_valid),
    .y_i     (CORD_W'(s_side.yaw_y)),
    .x_i     (CORD_W'(s_side.yaw_x)),
    .side_i  ({s_side.lock, s_side.p_pos}),
    .valid_o (y_valid),
    .angle_o (y_ang),
    .side_o  (y_sd)
  );

  // final fix-ups: lock-branch signs and pitch clamp
  always_comb begin
    y_mag = y_ang[15] ? -y_ang : y_ang;
    if (p_ang > PITCH_MAX) begin
      p_clamp = PITCH_MAX;
    end else if (p_ang < PITCH_MIN) begin
      p_clamp = PITCH_MIN;
    end else begin
      p_clamp = p_ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= r_valid && p_valid && y_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.gimbal_lock <= y_sd[1];
    res_q.roll_angle  <= r_lock ? 16'sd0 : r_ang;
    res_q.pitch_angle <= p_sd[1] ? (p_sd[0] ? PITCH_MIN : PITCH_MAX) : p_clamp;
    res_q.yaw_angle   <= y_sd[1] ? (y_sd[0] ? y_mag : -y_mag) : y_ang;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // checks
  `Q2E_ASSERT_DELAY(a_latency, start, LAT, done_o)
  `Q2E_ASSERT_IMPL(a_lanes_aligned, r_valid || p_valid || y_valid, r_valid && p_valid && y_valid)
  `Q2E_ASSERT_IMPL(a_pitch_range, done_o, result_o.pitch_angle <= PITCH_MAX && result_o.pitch_angle >= PITCH_MIN)
  `Q2E_ASSERT_IMPL(a_lock_roll, done_o && result_o.gimbal_lock, result_o.roll_angle == 16'sd0)
endmodule

@@ src/q2e_front.sv @@
// Front end: quaternion products, branch select and the radicand 1 - p^2.
// Depends on q2e_pkg.
module q2e_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  q2e_pkg::quat_t  quat_i,
  output logic            valid_o,
  output q2e_pkg::side_t  side_o,
  output logic [q2e_pkg::SQ_RAD_W-1:0] rad_o
);
  import q2e_pkg::*;

  logic [3:0] v_q;
  logic signed [31:0] xz_q, wy_q, xy_q, wz_q, yz_q, wx_q, xx_q, yy_q, zz_q;
  side_t side_b_q, side_c_q, side_d_q;
  logic signed [NP_W-2:0] p29_q;
  logic [SQ_RAD_W-2:0] psq_q;
  logic [SQ_RAD_W-1:0] rad_q;

  // branch logic for stage B
  logic signed [SUM_W-1:0] dif, yaw_y_l, yaw_y_n, yaw_x_l, yaw_x_n, half;
  logic signed [P_W-1:0] p;
  logic lock;
  logic signed [SQ_RAD_W-1:0] psq_full;

  always_comb begin
    half    = SUM_W'(34'sd134217728);
    dif     = SUM_W'(xz_q) - SUM_W'(wy_q);
    p       = {dif, 1'b0};
    lock    = (p >= P_W'(35'sd268435456)) || (p <= -P_W'(35'sd268435456));
    yaw_y_l = SUM_W'(xy_q) - SUM_W'(wz_q);
    yaw_y_n = SUM_W'(xy_q) + SUM_W'(wz_q);
    yaw_x_l = SUM_W'(xz_q) + SUM_W'(wy_q);
    yaw_x_n = half - (SUM_W'(yy_q) + SUM_W'(zz_q));
    psq_full = SQ_RAD_W'(p29_q * p29_q);
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  // stage A: products; B: sums; C: p squared; D: radicand
  always_ff @(posedge clk_i) begin
    xz_q <= quat_i.quat_x * quat_i.quat_z;
    wy_q <= quat_i.quat_w * quat_i.quat_y;
    xy_q <= quat_i.quat_x * quat_i.quat_y;
    wz_q <= quat_i.quat_w * quat_i.quat_z;
    yz_q <= quat_i.quat_y * quat_i.quat_z;
    wx_q <= quat_i.quat_w * quat_i.quat_x;
    xx_q <= quat_i.quat_x * quat_i.quat_x;
    yy_q <= quat_i.quat_y * quat_i.quat_y;
    zz_q <= quat_i.quat_z * quat_i.quat_z;

    side_b_q.lock   <= lock;
    side_b_q.p_pos  <= p > P_W'(0);
    // non-lock p fits the low bits as a signed value
    side_b_q.neg_p  <= -$signed(p[NP_W-1:0]);
    side_b_q.roll_y <= SUM_W'(yz_q) + SUM_W'(wx_q);
    side_b_q.roll_x <= half - (SUM_W'(xx_q) + SUM_W'(yy_q));
    side_b_q.yaw_y  <= lock ? yaw_y_l : yaw_y_n;
    side_b_q.yaw_x  <= lock ? yaw_x_l : yaw_x_n;
    p29_q           <= p[NP_W-2:0];

    side_c_q <= side_b_q;
    psq_q    <= psq_full[SQ_RAD_W-2:0];

    side_d_q <= side_c_q;
    rad_q    <= SQ_RAD_W'(58'h100_0000_0000_0000) - {1'b0, psq_q};
  end

  assign valid_o = v_q[3];
  assign side_o  = side_d_q;
  assign rad_o   = rad_q;
endmodule

@@ src/q2e_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, with a
// sideband that travels alongside. Depends on q2e_pkg.
module q2e_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [q2e_pkg::SQ_RAD_W-1:0]  rad_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          valid_o,
  output logic [q2e_pkg::SQ_ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0]             side_o
);
  import q2e_pkg::*;

  logic [SQ_ROOT_W:0]   v_q;
  logic [SQ_REM_W-1:0]  rr_q   [SQ_ROOT_W+1];
  logic [SQ_ROOT_W-1:0] root_q [SQ_ROOT_W+1];
  logic [SQ_RAD_W-1:0]  rad_q  [SQ_ROOT_W+1];
  logic [SIDE_W-1:0]    sd_q   [SQ_ROOT_W+1];

  // stage 0 is the input itself
  assign v_q[0]    = valid_i;
  assign rr_q[0]   = '0;
  assign root_q[0] = '0;
  assign rad_q[0]  = rad_i;
  assign sd_q[0]   = side_i;

  for (genvar k = 0; k < SQ_ROOT_W; k++) begin : g_stage
    localparam int Idx = 2 * (SQ_ROOT_W - 1 - k);
    logic [SQ_REM_W-1:0] rr_sh, trial;
    logic ge;

    // bring down two radicand bits, try (4q + 1)
    always_comb begin
      rr_sh = {rr_q[k][SQ_REM_W-3:0], rad_q[k][Idx+1:Idx]};
      trial = {1'b0, root_q[k], 2'b01};
      ge    = rr_sh >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rr_q[k+1]   <= ge ? rr_sh - trial : rr_sh;
      root_q[k+1] <= {root_q[k][SQ_ROOT_W-2:0], ge};
      rad_q[k+1]  <= rad_q[k];
      sd_q[k+1]   <= sd_q[k];
    end
  end

  assign valid_o = v_q[SQ_ROOT_W];
  assign root_o  = root_q[SQ_ROOT_W];
  assign side_o  = sd_q[SQ_ROOT_W];
endmodule

@@ src/q2e_cordic.sv @@
// Pipelined vectoring CORDIC giving atan2(y, x) as a 16-bit binary angle.
// Depends on q2e_pkg for the arctangent table.
module q2e_cordic #(
  parameter int STAGES = q2e_pkg::CORDIC_STAGES_DEF,
  parameter int W      = q2e_pkg::CORD_W,
  parameter int SIDE_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic signed [W-1:0] y_i,
  input  logic signed [W-1:0] x_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic signed [15:0]  angle_o,
  output logic [SIDE_W-1:0]   side_o
);
  import q2e_pkg::*;

  localparam int NS = (STAGES > ATAN_LEN) ? ATAN_LEN : STAGES;

  logic [NS:0]         v_q;
  logic signed [W-1:0] x_q   [NS+1];
  logic signed [W-1:0] y_q   [NS+1];
  logic [31:0]         acc_q [NS+1];
  logic                zero_q[NS+1];
  logic [SIDE_W-1:0]   sd_q  [NS+1];
  logic                vo_q;
  logic signed [15:0]  ang_q;
  logic [SIDE_W-1:0]   sdo_q;
  logic [31:0]         rnd;

  // entry: fold left half-plane onto the right
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= x_i[W-1] ? -x_i : x_i;
    y_q[0]    <= x_i[W-1] ? -y_i : y_i;
    acc_q[0]  <= x_i[W-1] ? 32'h8000_0000 : 32'h0;
    zero_q[0] <= (x_i == '0) && (y_i == '0);
    sd_q[0]   <= side_i;
  end

  // micro-rotations
  for (genvar i = 0; i < NS; i++) begin : g_rot
    logic signed [W-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (!y_q[i][W-1]) begin
        x_q[i+1]   <= x_q[i] + ys;
        y_q[i+1]   <= y_q[i] - xs;
        acc_q[i+1] <= acc_q[i] + ATAN_TAB[i];
      end else begin
        x_q[i+1]   <= x_q[i] - ys;
        y_q[i+1]   <= y_q[i] + xs;
        acc_q[i+1] <= acc_q[i] - ATAN_TAB[i];
      end
      zero_q[i+1] <= zero_q[i];
      sd_q[i+1]   <= sd_q[i];
    end
  end

  // round to 16 bits
  assign rnd = acc_q[NS] + 32'h0000_8000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= v_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q <= zero_q[NS] ? 16'sd0 : rnd[31:16];
    sdo_q <= sd_q[NS];
  end

  assign valid_o = vo_q;
  assign angle_o = ang_q;
  assign side_o  = sdo_q;
endmodule
